// ===== rtl/core/two_link_arm_inverse_kinematics_defines.svh =====
// ----------------------------------------------------------------------------
// two-link arm solver assertion macros
// shared concurrent check forms, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_DEFINES_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TLAIK_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// next-cycle implication
`define TLAIK_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define TLAIK_ASSERT_IMP(name, clk_s, rst_s, ante, cons)
`define TLAIK_ASSERT_NXT(name, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== rtl/core/tlaik_pkg.sv =====
// ----------------------------------------------------------------------------
// tlaik_pkg
// widths, angle constants and arctangent table of the two-link arm solver
// ----------------------------------------------------------------------------
package tlaik_pkg;

  localparam int COORD_W   = 16;
  localparam int LEN_W     = 15;
  localparam int ANGLE_W   = 16;
  localparam int CFG_IDX_W = 1;

  // datapath widths
  localparam int DW     = 36;   // cordic vectors and angles, 2^-30 rad
  localparam int AW     = 37;   // angle sums before wrap
  localparam int SQ_W   = 30;   // squared link length
  localparam int R2_W   = 32;   // squared reach
  localparam int MAG_W  = 32;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;

  // arctangent unit: sign fold, right normalize, five left normalize steps
  localparam int ATAN_PRE_STAGES = 7;
  localparam int ATAN_TABLE_LEN  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINK1 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK2 = 1'd1;

  localparam logic [LEN_W-1:0] LINK_RESET = 15'd512;

  localparam logic signed [DW-1:0] PI_Z     = 36'sd3373259426;
  localparam logic signed [AW-1:0] PI_A     = 37'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_A = 37'sd6746518852;

  localparam logic [31:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage

// ===== rtl/core/tlaik_ifs.sv =====
// ----------------------------------------------------------------------------
// tlaik channel interfaces
// target point, joint angle and register write channels
// ----------------------------------------------------------------------------
interface tlaik_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tlaik_pkg::COORD_W-1:0]   target_x;
  logic signed [tlaik_pkg::COORD_W-1:0]   target_y;
  modport source (output valid, output target_x, output target_y, input ready);
  modport sink (input valid, input target_x, input target_y, output ready);
endinterface

interface tlaik_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tlaik_pkg::ANGLE_W-1:0]   shoulder_angle;
  logic signed [tlaik_pkg::ANGLE_W-1:0]   elbow_angle;
  logic                                   out_of_reach;
  modport source (output valid, output shoulder_angle, output elbow_angle,
                  output out_of_reach, input ready);
  modport sink (input valid, input shoulder_angle, input elbow_angle,
                input out_of_reach, output ready);
endinterface

interface tlaik_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [tlaik_pkg::CFG_IDX_W-1:0]        index;
  logic [tlaik_pkg::LEN_W-1:0]            data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tlaik_atan2.sv =====
// ----------------------------------------------------------------------------
// tlaik_atan2
// pipelined vectoring cordic, atan2(y, x) in units of 2^-30 rad
// ----------------------------------------------------------------------------
module tlaik_atan2 #(
  parameter int ITERATIONS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [tlaik_pkg::DW-1:0] x_in,
  input  logic signed [tlaik_pkg::DW-1:0] y_in,
  output logic signed [tlaik_pkg::DW-1:0] z_out
);
  import tlaik_pkg::*;

  localparam int LAT = ATAN_PRE_STAGES + ITERATIONS;

  logic signed [DW-1:0] sx [LAT];
  logic signed [DW-1:0] sy [LAT];
  logic signed [DW-1:0] sz [LAT];
  logic                 sspec [LAT];   // y was zero, result is 0 or pi
  logic                 sneg  [LAT];   // x was negative

  // fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      sspec[0] <= (y_in == '0);
      sneg[0]  <= x_in[DW-1];
      if (x_in[DW-1]) begin
        sx[0] <= -x_in;
        sy[0] <= -y_in;
        sz[0] <= y_in[DW-1] ? -PI_Z : PI_Z;
      end else begin
        sx[0] <= x_in;
        sy[0] <= y_in;
        sz[0] <= '0;
      end
    end
  end

  for (genvar k = 1; k < LAT; k++) begin : g_stage
    logic signed [DW-1:0] xn, yn, zn;

    if (k == 1) begin : g_rshift
      logic signed [DW-1:0] ax, ay;
      logic [DW-1:0]        m;
      // at most one halving brings the larger magnitude below 2^31
      always_comb begin
        ax = sx[k-1][DW-1] ? -sx[k-1] : sx[k-1];
        ay = sy[k-1][DW-1] ? -sy[k-1] : sy[k-1];
        m  = ax | ay;
        zn = sz[k-1];
        if ((|m[DW-1:31])) begin
          xn = sx[k-1] >>> 1;
          yn = sy[k-1] >>> 1;
        end else begin
          xn = sx[k-1];
          yn = sy[k-1];
        end
      end
    end else if (k < ATAN_PRE_STAGES) begin : g_lshift
      localparam int SH = 16 >> (k - 2);
      logic signed [DW-1:0] ax, ay;
      logic [DW-1:0]        m;
      always_comb begin
        ax = sx[k-1][DW-1] ? -sx[k-1] : sx[k-1];
        ay = sy[k-1][DW-1] ? -sy[k-1] : sy[k-1];
        m  = ax | ay;
        zn = sz[k-1];
        if (m[DW-1:31-SH] == '0) begin
          xn = sx[k-1] <<< SH;
          yn = sy[k-1] <<< SH;
        end else begin
          xn = sx[k-1];
          yn = sy[k-1];
        end
      end
    end else begin : g_rot
      localparam int I = k - ATAN_PRE_STAGES;
      localparam logic signed [DW-1:0] T = $signed({{(DW-32){1'b0}}, ATAN_TABLE[I]});
      logic signed [DW-1:0] xs, ys;
      always_comb begin
        xs = sx[k-1] >>> I;
        ys = sy[k-1] >>> I;
        if (!sy[k-1][DW-1]) begin
          xn = sx[k-1] + ys;
          yn = sy[k-1] - xs;
          zn = sz[k-1] + T;
        end else begin
          xn = sx[k-1] - ys;
          yn = sy[k-1] + xs;
          zn = sz[k-1] - T;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx[k]    <= xn;
        sy[k]    <= yn;
        sz[k]    <= zn;
        sspec[k] <= sspec[k-1];
        sneg[k]  <= sneg[k-1];
      end
    end
  end

  assign z_out = sspec[LAT-1] ? (sneg[LAT-1] ? PI_Z : '0) : sz[LAT-1];

endmodule

// ===== rtl/core/two_link_arm_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics
// shoulder and elbow angles of a two-link planar arm for a target point
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   transaction
//  cfg      in   index, data (link length, Q7.8)           valid & ready
//  point    in   target_x, target_y (Q8.8)                 valid & ready
//  joints   out  shoulder_angle, elbow_angle, out_of_reach valid & ready
//
//  one transaction per cycle is taken while joints does not stall; the pipeline
//  depth is set by the 32-step square root and the cordic iteration stages
//  reset (rst, synchronous) empties the pipeline and loads 2.0 into both links
//  a stall at joints freezes the whole pipeline, point.ready follows it
//  cfg is always ready; the user must write only while the pipeline is empty (not enforced)
`include "two_link_arm_inverse_kinematics_defines.svh"

module two_link_arm_inverse_kinematics #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS   = 13
) (
  input logic        clk,
  input logic        rst,
  tlaik_cfg_if.sink  cfg,
  tlaik_in_if.sink   point,
  tlaik_out_if.source joints
);
  import tlaik_pkg::*;

  localparam int ATAN_LAT  = ATAN_PRE_STAGES + CORDIC_ITERATIONS;
  localparam int NST       = 4 + ROOT_W + ATAN_LAT + 4;
  localparam int RND_SHIFT = 30 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] RND_HALF = $signed({{(AW-1){1'b0}}, 1'b1}) <<< (RND_SHIFT-1);

  // ---------------------------------------------------------------- config
  logic [LEN_W-1:0] link1;
  logic [LEN_W-1:0] link2;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link1 <= LINK_RESET;
      link2 <= LINK_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LINK1: link1 <= cfg.data;
        REG_LINK2: link2 <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // single enable for every stage; the output register is the last stage
  logic           adv;
  logic [NST-1:0] vld;

  assign adv         = !vld[NST-1] || joints.ready;
  assign point.ready = adv;
  assign joints.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], point.valid};
    end
  end

  // ---------------------------------------------------------------- stage 1: squares
  logic signed [COORD_W-1:0] s1_x, s1_y;
  logic [30:0]               s1_xx, s1_yy;
  logic [SQ_W-1:0]           s1_l1sq, s1_l2sq;
  logic signed [31:0]        xx_full, yy_full;

  assign xx_full = point.target_x * point.target_x;
  assign yy_full = point.target_y * point.target_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x    <= point.target_x;
      s1_y    <= point.target_y;
      s1_xx   <= xx_full[30:0];
      s1_yy   <= yy_full[30:0];
      s1_l1sq <= link1 * link1;
      s1_l2sq <= link2 * link2;
    end
  end

  // ---------------------------------------------------------------- stage 2: reach, cosine terms
  logic signed [COORD_W-1:0] s2_x, s2_y;
  logic [R2_W-1:0]           s2_r2;
  logic [SQ_W-1:0]           s2_l1sq;
  logic signed [DW-1:0]      s2_a, s2_b;
  logic [R2_W-1:0]           r2;
  logic signed [DW-1:0]      l1sq_e, l2sq_e, r2_e;

  assign r2     = {1'b0, s1_xx} + {1'b0, s1_yy};
  assign l1sq_e = $signed({{(DW-SQ_W){1'b0}}, s1_l1sq});
  assign l2sq_e = $signed({{(DW-SQ_W){1'b0}}, s1_l2sq});
  assign r2_e   = $signed({{(DW-R2_W){1'b0}}, r2});

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x    <= s1_x;
      s2_y    <= s1_y;
      s2_r2   <= r2;
      s2_l1sq <= s1_l1sq;
      s2_a    <= l1sq_e + r2_e - l2sq_e;
      s2_b    <= l1sq_e + l2sq_e - r2_e;
    end
  end

  // ---------------------------------------------------------------- stage 3: A^2 and 4*L1^2*R2
  logic signed [COORD_W-1:0] s3_x, s3_y;
  logic signed [DW-1:0]      s3_a, s3_b;
  logic [RAD_W-1:0]          s3_asq, s3_big;
  logic                      s3_r2zero;
  logic signed [DW-1:0]      a_abs;
  logic [MAG_W-1:0]          amag;
  logic [RAD_W-3:0]          big_w;

  assign a_abs = s2_a[DW-1] ? -s2_a : s2_a;
  assign amag  = a_abs[MAG_W-1:0];
  assign big_w = s2_l1sq * s2_r2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x      <= s2_x;
      s3_y      <= s2_y;
      s3_a      <= s2_a;
      s3_b      <= s2_b;
      s3_asq    <= amag * amag;
      s3_big    <= {big_w, 2'b00};
      s3_r2zero <= (s2_r2 == '0);
    end
  end

  // ---------------------------------------------------------------- stage 4: reach test
  logic signed [COORD_W-1:0] s4_x, s4_y;
  logic signed [DW-1:0]      s4_a, s4_b;
  logic [RAD_W-1:0]          s4_d;
  logic                      s4_oor;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_x   <= s3_x;
      s4_y   <= s3_y;
      s4_a   <= s3_a;
      s4_b   <= s3_b;
      s4_d   <= s3_big - s3_asq;
      s4_oor <= s3_r2zero || (s3_asq > s3_big);
    end
  end

  // ---------------------------------------------------------------- square root, one bit a stage
  logic [REM_W-1:0]          sq_rem  [ROOT_W];
  logic [ROOT_W-1:0]         sq_root [ROOT_W];
  logic [RAD_W-1:0]          sq_rad  [ROOT_W];
  logic signed [COORD_W-1:0] sq_x    [ROOT_W];
  logic signed [COORD_W-1:0] sq_y    [ROOT_W];
  logic signed [DW-1:0]      sq_a    [ROOT_W];
  logic signed [DW-1:0]      sq_b    [ROOT_W];
  logic                      sq_oor  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [REM_W-1:0]          rem_prev, rem_sh, trial;
    logic [ROOT_W-1:0]         root_prev;
    logic [RAD_W-1:0]          rad_prev;
    logic signed [COORD_W-1:0] x_prev, y_prev;
    logic signed [DW-1:0]      a_prev, b_prev;
    logic                      oor_prev;

    if (j == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = s4_d;
      assign x_prev    = s4_x;
      assign y_prev    = s4_y;
      assign a_prev    = s4_a;
      assign b_prev    = s4_b;
      assign oor_prev  = s4_oor;
    end else begin : g_next
      assign rem_prev  = sq_rem[j-1];
      assign root_prev = sq_root[j-1];
      assign rad_prev  = sq_rad[j-1];
      assign x_prev    = sq_x[j-1];
      assign y_prev    = sq_y[j-1];
      assign a_prev    = sq_a[j-1];
      assign b_prev    = sq_b[j-1];
      assign oor_prev  = sq_oor[j-1];
    end

    assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_prev, 2'b01});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_sh >= trial) begin
          sq_rem[j]  <= rem_sh - trial;
          sq_root[j] <= {root_prev[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[j]  <= rem_sh;
          sq_root[j] <= {root_prev[ROOT_W-2:0], 1'b0};
        end
        sq_rad[j] <= rad_prev << 2;
        sq_x[j]   <= x_prev;
        sq_y[j]   <= y_prev;
        sq_a[j]   <= a_prev;
        sq_b[j]   <= b_prev;
        sq_oor[j] <= oor_prev;
      end
    end
  end

  // ---------------------------------------------------------------- three arctangents
  logic signed [DW-1:0] s_e, theta, alpha, gamma;

  assign s_e = $signed({{(DW-ROOT_W){1'b0}}, sq_root[ROOT_W-1]});

  tlaik_atan2 #(.ITERATIONS(CORDIC_ITERATIONS)) u_theta (
    .clk(clk), .en(adv),
    .x_in(DW'(sq_x[ROOT_W-1])), .y_in(DW'(sq_y[ROOT_W-1])),
    .z_out(theta)
  );

  tlaik_atan2 #(.ITERATIONS(CORDIC_ITERATIONS)) u_alpha (
    .clk(clk), .en(adv), .x_in(sq_a[ROOT_W-1]), .y_in(s_e), .z_out(alpha)
  );

  tlaik_atan2 #(.ITERATIONS(CORDIC_ITERATIONS)) u_gamma (
    .clk(clk), .en(adv), .x_in(sq_b[ROOT_W-1]), .y_in(s_e), .z_out(gamma)
  );

  // side bits ride alongside the arctangent pipelines
  logic sb_xneg [ATAN_LAT];
  logic sb_oor  [ATAN_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_xneg[0] <= sq_x[ROOT_W-1][COORD_W-1];
      sb_oor[0]  <= sq_oor[ROOT_W-1];
      for (int k = 1; k < ATAN_LAT; k++) begin
        sb_xneg[k] <= sb_xneg[k-1];
        sb_oor[k]  <= sb_oor[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- combine, wrap, round
  logic signed [AW-1:0] th_e, al_e, ga_e;
  logic signed [AW-1:0] c_sh, c_el, w1_sh, w1_el, w2_sh, w2_el;
  logic                 c_oor, w1_oor, w2_oor;

  assign th_e = AW'(theta);
  assign al_e = AW'(alpha);
  assign ga_e = AW'(gamma);

  always_ff @(posedge clk) begin
    if (adv) begin
      // mirrored elbow for targets left of the shoulder
      if (sb_xneg[ATAN_LAT-1]) begin
        c_sh <= th_e - al_e;
        c_el <= PI_A - ga_e;
      end else begin
        c_sh <= th_e + al_e;
        c_el <= ga_e - PI_A;
      end
      c_oor <= sb_oor[ATAN_LAT-1];

      w1_sh  <= (c_sh > PI_A) ? c_sh - TWO_PI_A : c_sh;
      w1_el  <= (c_el > PI_A) ? c_el - TWO_PI_A : c_el;
      w1_oor <= c_oor;

      w2_sh  <= (w1_sh <= -PI_A) ? w1_sh + TWO_PI_A : w1_sh;
      w2_el  <= (w1_el <= -PI_A) ? w1_el + TWO_PI_A : w1_el;
      w2_oor <= w1_oor;
    end
  end

  // round half up to the output fraction width
  logic signed [AW-1:0] rnd_sh, rnd_el;

  assign rnd_sh = (w2_sh + RND_HALF) >>> RND_SHIFT;
  assign rnd_el = (w2_el + RND_HALF) >>> RND_SHIFT;

  always_ff @(posedge clk) begin
    if (adv) begin
      joints.shoulder_angle <= w2_oor ? '0 : rnd_sh[ANGLE_W-1:0];
      joints.elbow_angle    <= w2_oor ? '0 : rnd_el[ANGLE_W-1:0];
      joints.out_of_reach   <= w2_oor;
    end
  end

  // ---------------------------------------------------------------- checks
  `TLAIK_ASSERT_IMP(a_oor_zero, clk, rst, joints.valid && joints.out_of_reach,
                    joints.shoulder_angle == '0 && joints.elbow_angle == '0)
  `TLAIK_ASSERT_IMP(a_stall_only_on_backpressure, clk, rst, !point.ready,
                    joints.valid && !joints.ready)
  `TLAIK_ASSERT_NXT(a_drain, clk, rst, joints.valid && joints.ready && !vld[NST-2],
                    !joints.valid)

endmodule
